// ===== sv/affine_to_translation_quaternion_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the affine to translation quaternion unit
// Shared property forms, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TO_TRANSLATION_QUATERNION_UNIT_DEFINES_SVH
`define AFFINE_TO_TRANSLATION_QUATERNION_UNIT_DEFINES_SVH

// Same-cycle implication.
`define AQT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AQT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/aqt_pkg.sv =====
// ----------------------------------------------------------------------------
// aqt_pkg
// Widths, constants and the queue entry type of the quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aqt_pkg;

    localparam int unsigned CompW            = 35;
    localparam int unsigned MagW             = 31;
    localparam int unsigned RootW            = 32;
    localparam int unsigned SumW             = 64;
    localparam int unsigned FifoDepthDefault = 4;

    localparam logic signed [CompW-1:0] RadOne  = 35'sd536870912;
    localparam logic        [31:0]      QuatOne = 32'h4000_0000;

    typedef struct packed {
        logic [31:0]                 tz;
        logic [31:0]                 ty;
        logic [31:0]                 tx;
        logic                        degen;
        logic [3:0][CompW-1:0]       comp;
    } item_t;

endpackage

`default_nettype wire

// ===== sv/aqt_front.sv =====
// ----------------------------------------------------------------------------
// aqt_front
// Classifies a transform: picks the branch and forms the unscaled quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module aqt_front (
    input  wire logic [383:0]        s_tdata,
    output aqt_pkg::item_t           item
);

    logic signed [aqt_pkg::CompW-1:0] w [3][3];
    logic signed [aqt_pkg::CompW-1:0] tr;
    logic signed [aqt_pkg::CompW-1:0] rad;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w[r][c] = {{3{s_tdata[(r*3+c)*32+31]}}, s_tdata[(r*3+c)*32 +: 32]};
            end
        end
    end

    assign tr = w[0][0] + w[1][1] + w[2][2];

    always_comb begin
        item.tx = s_tdata[319:288];
        item.ty = s_tdata[351:320];
        item.tz = s_tdata[383:352];
        if (tr > 0) begin
            rad = tr + aqt_pkg::RadOne;
            item.comp[3] = rad;
            item.comp[0] = w[2][1] - w[1][2];
            item.comp[1] = w[0][2] - w[2][0];
            item.comp[2] = w[1][0] - w[0][1];
        end else if (w[2][2] > w[0][0] && w[2][2] > w[1][1]
                     || w[1][1] > w[0][0] && w[2][2] > w[1][1]) begin
            rad = w[2][2] - w[0][0] - w[1][1] + aqt_pkg::RadOne;
            item.comp[2] = rad;
            item.comp[3] = w[1][0] - w[0][1];
            item.comp[0] = w[0][2] + w[2][0];
            item.comp[1] = w[1][2] + w[2][1];
        end else if (w[1][1] > w[0][0]) begin
            rad = w[1][1] - w[2][2] - w[0][0] + aqt_pkg::RadOne;
            item.comp[1] = rad;
            item.comp[3] = w[0][2] - w[2][0];
            item.comp[2] = w[2][1] + w[1][2];
            item.comp[0] = w[0][1] + w[1][0];
        end else begin
            rad = w[0][0] - w[1][1] - w[2][2] + aqt_pkg::RadOne;
            item.comp[0] = rad;
            item.comp[3] = w[2][1] - w[1][2];
            item.comp[1] = w[1][0] + w[0][1];
            item.comp[2] = w[2][0] + w[0][2];
        end
        item.degen = (rad <= 0);
    end

endmodule

`default_nettype wire

// ===== sv/aqt_fifo.sv =====
// ----------------------------------------------------------------------------
// aqt_fifo
// Short queue of classified transforms between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module aqt_fifo #(
    parameter int unsigned DEPTH = aqt_pkg::FifoDepthDefault
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire aqt_pkg::item_t  push_item,
    input  wire logic            pop,
    output aqt_pkg::item_t       head,
    output logic                 full,
    output logic                 empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    aqt_pkg::item_t  mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full  = (count_reg == CntW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/aqt_back.sv =====
// ----------------------------------------------------------------------------
// aqt_back
// Normalizes the quaternion: magnitudes, shift, squares, pipelined square root,
// four pipelined dividers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aqt_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire aqt_pkg::item_t  head,
    input  wire logic            head_valid,
    output logic                 pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [223:0]         m_tdata,   // trans_x, trans_y, trans_z, quat_x..quat_w
    output logic [0:0]           m_tuser    // degenerate
);

    localparam int unsigned CW = aqt_pkg::CompW;
    localparam int unsigned MW = aqt_pkg::MagW;
    localparam int unsigned RW = aqt_pkg::RootW;
    localparam int unsigned SW = aqt_pkg::SumW;

    typedef struct packed {
        logic               degen;
        logic [3:0]         neg;
        logic [3:0][MW-1:0] mag;
        logic [95:0]        trans;
    } side_t;

    logic enable;
    logic m_valid_reg;
    logic [223:0] m_data_reg;
    logic m_degen_reg;

    assign enable   = !m_valid_reg || m_tready;
    assign pop      = enable && head_valid;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_degen_reg;

    // Stage A: signs and magnitudes.
    logic          a_valid_reg;
    side_t         a_side_reg;
    logic [CW-1:0] a_mag_reg [4];
    logic [CW-1:0] a_or_reg;
    logic [CW-1:0] a_mag_next [4];

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            a_mag_next[n] = head.comp[n][CW-1] ? -head.comp[n] : head.comp[n];
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            a_side_reg.degen <= head.degen;
            a_side_reg.trans <= {head.tz, head.ty, head.tx};
            a_side_reg.mag   <= '0;
            for (int n = 0; n < 4; n++) begin
                a_side_reg.neg[n] <= head.comp[n][CW-1];
                a_mag_reg[n]      <= a_mag_next[n];
            end
            a_or_reg <= a_mag_next[0] | a_mag_next[1] | a_mag_next[2] | a_mag_next[3];
        end
    end

    // Stage B: shift so that the largest magnitude lies in [2^30, 2^31).
    logic [5:0]    bl;
    logic [CW-1:0] b_shift [4];
    logic          b_valid_reg;
    side_t         b_side_reg;

    always_comb begin
        bl = '0;
        for (int i = 0; i < CW; i++) begin
            if (a_or_reg[i]) begin
                bl = 6'(i + 1);
            end
        end
        for (int n = 0; n < 4; n++) begin
            if (bl > 6'd31) begin
                b_shift[n] = a_mag_reg[n] >> (bl - 6'd31);
            end else begin
                b_shift[n] = a_mag_reg[n] << (6'd31 - bl);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            b_side_reg.degen <= a_side_reg.degen;
            b_side_reg.neg   <= a_side_reg.neg;
            b_side_reg.trans <= a_side_reg.trans;
            for (int n = 0; n < 4; n++) begin
                b_side_reg.mag[n] <= b_shift[n][MW-1:0];
            end
        end
    end

    // Stage C: squares. The sum of squares enters the square root.
    logic            c_valid_reg;
    side_t           c_side_reg;
    logic [2*MW-1:0] c_sq_reg [4];

    always_ff @(posedge aclk) begin
        if (enable) begin
            c_side_reg <= b_side_reg;
            for (int n = 0; n < 4; n++) begin
                c_sq_reg[n] <= b_side_reg.mag[n] * b_side_reg.mag[n];
            end
        end
    end

    // Square root, one result bit per stage.
    logic          sq_valid_reg [RW+1];
    side_t         sq_side_reg  [RW+1];
    logic [SW-1:0] sq_rad_reg   [RW+1];
    logic [33:0]   sq_rem_reg   [RW+1];
    logic [RW-1:0] sq_root_reg  [RW+1];
    logic [35:0]   sq_trial     [RW];
    logic [35:0]   sq_test      [RW];

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            sq_trial[k] = {sq_rem_reg[k], sq_rad_reg[k][SW-1:SW-2]};
            sq_test[k]  = {2'b00, sq_root_reg[k], 2'b01};
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            sq_side_reg[0] <= c_side_reg;
            sq_rad_reg[0]  <= SW'(c_sq_reg[0]) + SW'(c_sq_reg[1])
                            + SW'(c_sq_reg[2]) + SW'(c_sq_reg[3]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 0; k < RW; k++) begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
                if (sq_trial[k] >= sq_test[k]) begin
                    sq_rem_reg[k+1]  <= 34'(sq_trial[k] - sq_test[k]);
                    sq_root_reg[k+1] <= {sq_root_reg[k][RW-2:0], 1'b1};
                end else begin
                    sq_rem_reg[k+1]  <= sq_trial[k][33:0];
                    sq_root_reg[k+1] <= {sq_root_reg[k][RW-2:0], 1'b0};
                end
            end
        end
    end

    // Stage E: rounded numerators, then one quotient bit per stage.
    logic          dv_valid_reg [MW+1];
    side_t         dv_side_reg  [MW+1];
    logic [RW-1:0] dv_len_reg   [MW+1];
    logic [RW-1:0] dv_rem_reg   [MW+1][4];
    logic [MW-1:0] dv_low_reg   [MW+1][4];
    logic [MW-1:0] dv_q_reg     [MW+1][4];
    logic [61:0]   num          [4];
    logic [32:0]   dv_trial     [MW][4];

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            num[n] = {1'b0, sq_side_reg[RW].mag[n], 30'b0}
                   + 62'(sq_root_reg[RW] >> 1);
        end
        for (int k = 0; k < MW; k++) begin
            for (int n = 0; n < 4; n++) begin
                dv_trial[k][n] = {dv_rem_reg[k][n], dv_low_reg[k][n][MW-1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            dv_side_reg[0] <= sq_side_reg[RW];
            dv_len_reg[0]  <= sq_root_reg[RW];
            for (int n = 0; n < 4; n++) begin
                dv_rem_reg[0][n] <= {1'b0, num[n][61:31]};
                dv_low_reg[0][n] <= num[n][30:0];
                dv_q_reg[0][n]   <= '0;
            end
            for (int k = 0; k < MW; k++) begin
                dv_side_reg[k+1] <= dv_side_reg[k];
                dv_len_reg[k+1]  <= dv_len_reg[k];
                for (int n = 0; n < 4; n++) begin
                    dv_low_reg[k+1][n] <= dv_low_reg[k][n] << 1;
                    if (dv_trial[k][n] >= {1'b0, dv_len_reg[k]}) begin
                        dv_rem_reg[k+1][n] <= 32'(dv_trial[k][n] - {1'b0, dv_len_reg[k]});
                        dv_q_reg[k+1][n]   <= {dv_q_reg[k][n][MW-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[k+1][n] <= dv_trial[k][n][31:0];
                        dv_q_reg[k+1][n]   <= {dv_q_reg[k][n][MW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Output register with signs applied; the vector part is negated.
    logic [31:0] q_out [4];
    logic [31:0] q_abs [4];

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            q_abs[n] = {1'b0, dv_q_reg[MW][n]};
            if (dv_side_reg[MW].neg[n] ^ (n < 3)) begin
                q_out[n] = -q_abs[n];
            end else begin
                q_out[n] = q_abs[n];
            end
        end
        if (dv_side_reg[MW].degen) begin
            q_out[0] = '0;
            q_out[1] = '0;
            q_out[2] = '0;
            q_out[3] = aqt_pkg::QuatOne;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            m_data_reg  <= {q_out[3], q_out[2], q_out[1], q_out[0], dv_side_reg[MW].trans};
            m_degen_reg <= dv_side_reg[MW].degen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= RW; k++) begin
                sq_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= MW; k++) begin
                dv_valid_reg[k] <= 1'b0;
            end
        end else if (enable) begin
            a_valid_reg <= head_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            sq_valid_reg[0] <= c_valid_reg;
            for (int k = 0; k < RW; k++) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            dv_valid_reg[0] <= sq_valid_reg[RW];
            for (int k = 0; k < MW; k++) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
            m_valid_reg <= dv_valid_reg[MW];
        end
    end

endmodule

`default_nettype wire

// ===== sv/affine_to_translation_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// affine_to_translation_quaternion_unit
// Splits a row-vector affine transform into its translation and a unit
// rotation quaternion with the vector part negated.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock cycle while s_tready is high
// and delivers one result per cycle once its pipeline is full, unless
// m_tready holds the output; the pipeline holds the 32-stage square root
// and the 31-stage dividers. A queue of FIFO_DEPTH entries, four by default,
// sits between the classifier and the normalization pipeline, and m_tuser
// flags a degenerate rotation that returned the identity quaternion.
`default_nettype none

`include "affine_to_translation_quaternion_unit_defines.svh"

module affine_to_translation_quaternion_unit #(
    parameter int unsigned FIFO_DEPTH = aqt_pkg::FifoDepthDefault
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [383:0] s_tdata,   // rot_11..rot_33, offset_x, offset_y, offset_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [223:0]      m_tdata,   // trans_x..trans_z, quat_x, quat_y, quat_z, quat_w
    output logic [0:0]        m_tuser    // degenerate
);

    aqt_pkg::item_t front_item;
    aqt_pkg::item_t head;
    logic full, empty, push, pop;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    aqt_front u_front (
        .s_tdata (s_tdata),
        .item    (front_item)
    );

    aqt_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    aqt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    `AQT_ASSERT_IMP(a_degen_identity, m_tvalid && m_tuser[0],
        m_tdata[191:96] == 96'd0 && m_tdata[223:192] == aqt_pkg::QuatOne,
        "degenerate result is not the identity quaternion")
    `AQT_ASSERT_IMP(a_w_range, m_tvalid && !m_tuser[0],
        $signed(m_tdata[223:192]) <= 32'sh4000_0000
        && $signed(m_tdata[223:192]) >= -32'sh4000_0000,
        "quaternion w outside the unit range")
    `AQT_ASSERT_IMP(a_full_by_write, $fell(s_tready), $past(s_tvalid),
        "queue filled without an input transaction")

endmodule

`default_nettype wire

// ===== test/affine_to_translation_quaternion_unit_tb.sv =====
// ----------------------------------------------------------------------------
// affine_to_translation_quaternion_unit_tb
// Streams affine transforms into the unit, predicts the translation and the
// normalized, handedness-flipped quaternion of each one, and compares every
// result transaction against the oldest prediction under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_to_translation_quaternion_unit_tb;

    typedef struct {
        logic [31:0] tx, ty, tz, qx, qy, qz, qw;
        logic        degen;
    } pose_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [383:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;
    logic [0:0]   m_tuser;

    logic [383:0] xform_q[$];
    pose_t        pose_q[$];
    bit           stim_done = 1'b0;
    int           errors = 0;
    int           cycle = 0;
    int           send_wait = 0;
    int           recv_wait = 0;
    int           hold_off = 0;

    affine_to_translation_quaternion_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic pose_t predict_pose(logic [383:0] d);
        longint m[3][3];
        longint c[4];
        longint rad, tr;
        logic [63:0] mag[4], q, sumsq, len, maxm;
        bit neg[4], s;
        int i, j, k, bl;
        pose_t p;
        for (int r = 0; r < 3; r++)
            for (int cc = 0; cc < 3; cc++)
                m[r][cc] = longint'($signed(d[(r*3+cc)*32 +: 32]));
        p.tx = d[288 +: 32];
        p.ty = d[320 +: 32];
        p.tz = d[352 +: 32];
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            rad = tr + (64'sd1 << 29);
            c[3] = rad;
            c[0] = m[2][1] - m[1][2];
            c[1] = m[0][2] - m[2][0];
            c[2] = m[1][0] - m[0][1];
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = m[i][i] - m[j][j] - m[k][k] + (64'sd1 << 29);
            c[i] = rad;
            c[3] = m[k][j] - m[j][k];
            c[j] = m[j][i] + m[i][j];
            c[k] = m[k][i] + m[i][k];
        end
        if (rad <= 0) begin
            p.qx = 0; p.qy = 0; p.qz = 0; p.qw = 32'h4000_0000;
            p.degen = 1'b1;
            return p;
        end
        maxm = 0;
        for (int n = 0; n < 4; n++) begin
            neg[n] = c[n] < 0;
            mag[n] = neg[n] ? -c[n] : c[n];
            if (mag[n] > maxm) maxm = mag[n];
        end
        bl = 0;
        while (maxm != 0) begin
            bl++;
            maxm >>= 1;
        end
        sumsq = 0;
        for (int n = 0; n < 4; n++) begin
            if (bl > 31) mag[n] >>= (bl - 31);
            else mag[n] <<= (31 - bl);
            sumsq += mag[n] * mag[n];
        end
        len = int_sqrt(sumsq);
        for (int n = 0; n < 4; n++) begin
            q = (mag[n] * (64'd1 << 30) + (len >> 1)) / len;
            s = (n < 3) ? !neg[n] : neg[n];
            c[n] = s ? -longint'(q) : longint'(q);
        end
        p.qx = c[0][31:0]; p.qy = c[1][31:0]; p.qz = c[2][31:0]; p.qw = c[3][31:0];
        p.degen = 1'b0;
        return p;
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h2000_0000 - $urandom_range(0, 32'h0100_0000);
            2: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            3: return $urandom_range(0, 32'h0000_ffff) - 32'h0000_8000;
            4: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'h7fff_ffff - $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [383:0] pack_xform(logic [31:0] e[12]);
        logic [383:0] d;
        for (int n = 0; n < 12; n++) d[n*32 +: 32] = e[n];
        return d;
    endfunction

    initial begin
        logic [31:0] e[12];
        logic [31:0] one, h;
        one = 32'h2000_0000;
        // Identity, then rotations that hit each diagonal branch.
        e = '{one, 0, 0, 0, one, 0, 0, 0, one, 32'h7fff_ffff, 32'h8000_0000, 0};
        xform_q.insert(xform_q.size(), pack_xform(e));
        e = '{one, 0, 0, 0, -one, 0, 0, 0, -one, 32'h0001_0000, 0, 32'hffff_ffff};
        xform_q.insert(xform_q.size(), pack_xform(e));
        e = '{-one, 0, 0, 0, one, 0, 0, 0, -one, 1, 2, 3};
        xform_q.insert(xform_q.size(), pack_xform(e));
        e = '{-one, 0, 0, 0, -one, 0, 0, 0, one, 4, 5, 6};
        xform_q.insert(xform_q.size(), pack_xform(e));
        // Zero matrix and matrices with negative diagonal elements.
        e = '{default: 0};
        xform_q.insert(xform_q.size(), pack_xform(e));
        e = '{-one, 5, 7, 9, -one, 11, 13, 15, -one, 0, 0, 0};
        xform_q.insert(xform_q.size(), pack_xform(e));
        e = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0};
        xform_q.insert(xform_q.size(), pack_xform(e));
        // First diagonal element one LSB above the other two.
        e = '{-one + 1, 0, 0, 0, -one, 0, 0, 0, -one, 0, 0, 0};
        xform_q.insert(xform_q.size(), pack_xform(e));
        e = '{default: 32'h7fff_ffff};
        xform_q.insert(xform_q.size(), pack_xform(e));
        e = '{default: 32'h8000_0000};
        xform_q.insert(xform_q.size(), pack_xform(e));
        e = '{default: 32'hffff_ffff};
        xform_q.insert(xform_q.size(), pack_xform(e));
        // Trace ties between diagonal elements.
        e = '{0, one, 0, -one, 0, 0, 0, 0, 0, 0, 0, 0};
        xform_q.insert(xform_q.size(), pack_xform(e));
        h = 32'h1000_0000;
        e = '{h, h, -h, -h, h, h, h, -h, h, 0, 0, 0};
        xform_q.insert(xform_q.size(), pack_xform(e));
        for (int n = 0; n < 750; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                for (int m = 0; m < 12; m++) e[m] = $urandom();
            end else begin
                for (int m = 0; m < 9; m++) e[m] = rand_elem();
                for (int m = 9; m < 12; m++) e[m] = $urandom();
            end
            xform_q.insert(xform_q.size(), pack_xform(e));
        end
        stim_done = 1'b1;
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle == 11) aresetn <= 1'b1;
        if (cycle > 400000) begin
            $display("affine_to_translation_quaternion_unit verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pose_q.insert(pose_q.size(), predict_pose(s_tdata));
                if (send_wait == 0 && xform_q.size() > 0) begin
                    s_tdata <= xform_q.pop_front();
                    send_wait <= $urandom_range(0, 3);
                end else begin
                    s_tvalid <= 1'b0;
                    send_wait <= ($urandom_range(0, 3) == 0) ? 0 : send_wait;
                end
            end else if (!s_tvalid) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                end else if (xform_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= xform_q.pop_front();
                    send_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        pose_t p;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected transaction %h", $time, m_tdata);
                    errors++;
                end else begin
                    p = pose_q.pop_front();
                    if ({p.qw, p.qz, p.qy, p.qx, p.tz, p.ty, p.tx} !== m_tdata
                            || p.degen !== m_tuser[0]) begin
                        $display("%0t: expected %h/%b actual %h/%b", $time,
                                 {p.qw, p.qz, p.qy, p.qx, p.tz, p.ty, p.tx}, p.degen,
                                 m_tdata, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (cycle == 300) begin
                hold_off <= 200;
                m_tready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
            end else if (m_tready && m_tvalid) begin
                recv_wait <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 3);
                m_tready <= ($urandom_range(0, 1) == 0);
            end else if (!m_tready) begin
                if (recv_wait > 0) recv_wait <= recv_wait - 1;
                else m_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (stim_done && aresetn);
        wait (xform_q.size() == 0 && !s_tvalid && pose_q.size() == 0);
        repeat (150) @(posedge aclk);
        if (errors == 0 && pose_q.size() == 0) begin
            $display("affine_to_translation_quaternion_unit verification clean");
        end else begin
            $display("affine_to_translation_quaternion_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
